// ===== design/assert_macros.svh =====
// Assertion macros used by the top level of the crowd floor field block.
// Include this header with a bare file name; it has no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define CRF_ASSERT_IMPL(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define CRF_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== design/crf_pkg.sv =====
// Package for the crowd floor field block: payload types and fixed constants.
// No dependencies; the top level and the cell refer to it by scoped names.
package crf_pkg;

    localparam int VALUE_W  = 16;
    localparam int WEIGHT_W = 12;
    localparam int COUNT_W  = 10;
    localparam int FINAL_W  = 21;
    localparam int BASE_W   = VALUE_W + 4;

    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 12'd256;
    localparam logic [FINAL_W-1:0]  FINAL_MAX    = 21'h1F_FFFF;
    localparam logic [COUNT_W-2:0]  COUNT_SAT    = 9'd511;
    localparam logic signed [COUNT_W-1:0] WALL_COUNT = -10'sd1;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef logic [WEIGHT_W-1:0] weight_t;
    typedef logic signed [COUNT_W-1:0] count_t;

    typedef struct packed {
        logic               command;
        logic [VALUE_W-1:0] static_value;
        logic               is_wall;
        logic               last_cell;
    } in_item_t;

    typedef struct packed {
        logic signed [COUNT_W-1:0] dynamic_count;
        logic [FINAL_W-1:0]        final_value;
        logic                      overflow;
        logic                      last_out;
    } out_item_t;

endpackage

// ===== design/crf_stream_if.sv =====
// Valid/ready channel interface with a payload type parameter.
// Used for the input, result and configuration channels; no dependencies.
interface crf_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/crowd_rank_floor_field.sv =====
// Top level of the crowd floor field block: control, the occupant cell chain and
// the result stage. Depends on crf_pkg, crf_stream_if, crf_cell, assert_macros.svh.
//
// Usage:
// in_ch carries load and query transactions, out_ch one result transaction per
// query, cfg writes crowd_weight (taken on any cycle, ready is always high).
// A load shifts the occupant value into the head of the cell chain; loads
// beyond MAX_OCCUPANTS are dropped and set the sticky overflow.
// A non-wall query sends a token down the chain, one cell per cycle, counting
// occupants at or below the query value; the count times the weight is then
// registered, and the base is added and the sum saturated into the output
// register. A query marked last empties the store once its result is formed.
// The result sits in an output register; a later load is still taken while it
// waits, and a later query stalls only when its own result is ready to leave.
// Reset empties the store, clears overflow, sets the weight to 1.0 and drops
// any result not yet taken.
module crowd_rank_floor_field #(
    parameter int MAX_OCCUPANTS = 256
) (
    input  logic         clk,
    input  logic         rst_n,
    crf_stream_if.sink   in_ch,
    crf_stream_if.source out_ch,
    crf_stream_if.sink   cfg
);

    `include "assert_macros.svh"

    localparam int CNT_W  = $clog2(MAX_OCCUPANTS + 1);
    localparam int PROD_W = crf_pkg::WEIGHT_W + CNT_W;
    localparam int SUM_W  = ((PROD_W > crf_pkg::BASE_W) ? PROD_W : crf_pkg::BASE_W) + 1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_FIN  = 3'b100
    } state_t;

    state_t                        state_reg, state_next;
    crf_pkg::weight_t              weight_reg;
    logic [CNT_W-1:0]              occ_count_reg;
    logic                          dropped_reg;
    logic                          tok_start_reg;
    logic [crf_pkg::VALUE_W-1:0]   thr_reg;
    logic                          wall_reg;
    logic                          last_reg;
    logic [CNT_W-1:0]              n_reg;
    logic [PROD_W-1:0]             prod_reg;
    logic                          out_valid_reg;
    crf_pkg::out_item_t            out_data_reg;

    logic                          in_acc;
    logic                          is_load;
    logic                          store_full;
    logic                          shift_en;
    logic                          fin_go;
    logic [SUM_W-1:0]              sum;
    crf_pkg::out_item_t            fin_item;

    logic [crf_pkg::VALUE_W-1:0]   chain_val [MAX_OCCUPANTS+1];
    logic                          chain_tok [MAX_OCCUPANTS+1];
    logic [CNT_W-1:0]              chain_cnt [MAX_OCCUPANTS+1];

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_acc      = in_ch.valid && in_ch.ready;
    assign is_load     = (in_ch.data.command == crf_pkg::CMD_LOAD);
    assign store_full  = (32'(occ_count_reg) >= MAX_OCCUPANTS);
    assign shift_en    = in_acc && is_load && !store_full;
    assign fin_go      = (state_reg == ST_FIN) && (!out_valid_reg || out_ch.ready);

    assign cfg.ready = 1'b1;

    // Cell chain: values shift toward the tail on a load, the query token
    // walks toward the tail one cell per cycle.
    assign chain_val[0] = in_ch.data.static_value;
    assign chain_tok[0] = tok_start_reg;
    assign chain_cnt[0] = '0;

    for (genvar i = 0; i < MAX_OCCUPANTS; i++)
    begin : g_cell
        crf_cell #(
            .CNT_W (CNT_W)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .shift_en      (shift_en),
            .value_in      (chain_val[i]),
            .value_out     (chain_val[i+1]),
            .active        (32'(occ_count_reg) > i),
            .threshold     (thr_reg),
            .tok_valid_in  (chain_tok[i]),
            .tok_cnt_in    (chain_cnt[i]),
            .tok_valid_out (chain_tok[i+1]),
            .tok_cnt_out   (chain_cnt[i+1])
        );
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && !is_load)
                begin
                    state_next = in_ch.data.is_wall ? ST_FIN : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (chain_tok[MAX_OCCUPANTS])
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (fin_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result assembly: base plus weighted count, saturated to the Q13.8 range; a wall gives the base alone.
    always_comb
    begin
        sum = SUM_W'({thr_reg, 4'b0000}) + SUM_W'(prod_reg);
        fin_item.overflow = dropped_reg;
        fin_item.last_out = last_reg;
        if (wall_reg)
        begin
            fin_item.dynamic_count = crf_pkg::WALL_COUNT;
            fin_item.final_value   = crf_pkg::FINAL_W'({thr_reg, 4'b0000});
        end
        else
        begin
            if (32'(n_reg) > 32'(crf_pkg::COUNT_SAT))
            begin
                fin_item.dynamic_count = crf_pkg::count_t'(crf_pkg::COUNT_SAT);
            end
            else
            begin
                fin_item.dynamic_count = crf_pkg::count_t'(n_reg);
            end
            if (sum > SUM_W'(crf_pkg::FINAL_MAX))
            begin
                fin_item.final_value = crf_pkg::FINAL_MAX;
            end
            else
            begin
                fin_item.final_value = crf_pkg::FINAL_W'(sum);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            weight_reg    <= crf_pkg::WEIGHT_RESET;
            occ_count_reg <= '0;
            dropped_reg   <= 1'b0;
            tok_start_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tok_start_reg <= in_acc && !is_load && !in_ch.data.is_wall;
            if (cfg.valid)
            begin
                weight_reg <= cfg.data;
            end
            if (shift_en)
            begin
                occ_count_reg <= occ_count_reg + CNT_W'(1);
            end
            else if (fin_go && last_reg)
            begin
                occ_count_reg <= '0;
            end
            if (in_acc && is_load && store_full)
            begin
                dropped_reg <= 1'b1;
            end
            if (fin_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && !is_load)
        begin
            thr_reg  <= in_ch.data.static_value;
            wall_reg <= in_ch.data.is_wall;
            last_reg <= in_ch.data.last_cell;
        end
        if ((state_reg == ST_SCAN) && chain_tok[MAX_OCCUPANTS])
        begin
            n_reg    <= chain_cnt[MAX_OCCUPANTS];
            prod_reg <= PROD_W'(weight_reg) * PROD_W'(chain_cnt[MAX_OCCUPANTS]);
        end
        if (fin_go)
        begin
            out_data_reg <= fin_item;
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;

    // The token leaves the chain only while a scan is in progress.
    `CRF_ASSERT_IMPL(a_tail_in_scan, clk, rst_n, chain_tok[MAX_OCCUPANTS], state_reg == ST_SCAN)
    // A load with room left grows the store by exactly one entry.
    `CRF_ASSERT_NEXT(a_load_grows, clk, rst_n, shift_en, occ_count_reg == $past(occ_count_reg) + 1)
    // The last query of a scan leaves the store empty.
    `CRF_ASSERT_NEXT(a_last_clears, clk, rst_n, fin_go && last_reg, occ_count_reg == '0)

endmodule

// ===== design/crf_cell.sv =====
// One cell of the occupant chain: holds one stored occupant value and passes a
// query token with its running count to the next cell. Depends on crf_pkg.
module crf_cell #(
    parameter int CNT_W = 9
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        shift_en,
    input  logic [crf_pkg::VALUE_W-1:0] value_in,
    output logic [crf_pkg::VALUE_W-1:0] value_out,
    input  logic                        active,
    input  logic [crf_pkg::VALUE_W-1:0] threshold,
    input  logic                        tok_valid_in,
    input  logic [CNT_W-1:0]            tok_cnt_in,
    output logic                        tok_valid_out,
    output logic [CNT_W-1:0]            tok_cnt_out
);

    logic [crf_pkg::VALUE_W-1:0] value_reg;
    logic                        tok_valid_reg;
    logic [CNT_W-1:0]            tok_cnt_reg;
    logic [CNT_W-1:0]            tok_cnt_next;
    logic                        hit;

    // Only cells below the fill level hold a stored occupant.
    assign hit          = active && (value_reg <= threshold);
    assign tok_cnt_next = tok_cnt_in + CNT_W'(hit);

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            value_reg <= value_in;
        end
        tok_cnt_reg <= tok_cnt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            tok_valid_reg <= tok_valid_in;
        end
    end

    assign value_out     = value_reg;
    assign tok_valid_out = tok_valid_reg;
    assign tok_cnt_out   = tok_cnt_reg;

endmodule
